[rtl/core/npps_pkg.sv]
// shared types, constants and helpers for the next probable prime search block
`timescale 1ns / 1ps
`default_nettype none
package npps_pkg;

	// width of the start word and of the result word
	localparam int unsigned FIELD_W = 32;

	typedef logic [FIELD_W-1:0] field_t;
	typedef logic [2:0] small_res_t;

	// one bit of a msb-first residue walk: (2r + b) mod m, with r < m and m at most 7
	function automatic small_res_t res_step(input small_res_t r, input logic b,
			input small_res_t m);
		logic [3:0] t;
		t = {r, b};
		if (t >= {1'b0, m}) begin
			t = t - {1'b0, m};
		end
		return t[2:0];
	endfunction

endpackage
`default_nettype wire

[rtl/core/next_probable_prime_search_top.sv]
// next probable prime search: residue filter and iterative modular exponentiation
// sequencing: per candidate a residue walk over the W bits and the evaluate step, then for each
//   of bases 3 and 5 (W-1) squarings and up to (W-1) base multiplies, each a shift-and-add
//   modular multiply; after the last candidate the done state waits while a held result
//   is stalled, then loads the output word
// throughput: one word at a time, the next start is taken the cycle after the output loads
// reset: arst_n clears the sequencer and the result valid flag, no result pending
`timescale 1ns / 1ps
`default_nettype none
module next_probable_prime_search_top #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start_valid,
	output logic                  start_stall,
	input  wire npps_pkg::field_t start_value,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output npps_pkg::field_t      prime_found,
	output logic                  overflow
);
	import npps_pkg::*;

	localparam int unsigned W   = VALUE_WIDTH;
	localparam int unsigned CW  = (W > 1) ? $clog2(W) : 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RES  = 3'd1;
	localparam logic [2:0] S_EVAL = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_EXP  = 3'd4;
	localparam logic [2:0] S_NEXT = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	localparam small_res_t MOD3 = 3'd3;
	localparam small_res_t MOD5 = 3'd5;
	localparam small_res_t MOD7 = 3'd7;

	logic [2:0]    state_q;
	logic [W-1:0]  cand_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  mcand_q;
	logic [W-1:0]  mplier_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] ebit_q;
	logic          phase_q;
	logic          sq_q;
	logic          base5_q;
	logic          ovf_q;
	small_res_t    rm3_q;
	small_res_t    rm5_q;
	small_res_t    rm7_q;
	logic          res_valid_q;
	field_t        prime_q;
	logic          res_ovf_q;

	logic [63:0]   start_ext;
	logic          start_big;
	logic [W-1:0]  start_cand;
	logic [W-1:0]  cand_plus2;
	logic [W-1:0]  exp_word;
	logic [W-1:0]  base_val;
	logic [W-1:0]  addend;
	logic [W:0]    sum;
	logic [W:0]    diff;
	logic [W-1:0]  red;
	logic [63:0]   cand_ext;
	logic          out_free;
	logic          pass;

	assign start_ext  = 64'(start_value);
	assign start_big  = (start_ext >> W) != 64'd0;
	// an even start moves up to the next odd value
	assign start_cand = start_ext[W-1:0] | W'(1);
	assign cand_plus2 = cand_q + W'(2);
	assign exp_word   = cand_q >> 1;
	assign base_val   = base5_q ? W'(5) : W'(3);
	assign cand_ext   = 64'(cand_q);

	// shared add and reduce: doubles acc in phase 0, adds the multiplicand in phase 1
	assign addend = phase_q ? mcand_q : acc_q;
	assign sum    = {1'b0, acc_q} + {1'b0, addend};
	assign diff   = sum - {1'b0, cand_q};
	assign red    = (sum >= {1'b0, cand_q}) ? diff[W-1:0] : sum[W-1:0];

	// euler test outcome: 1 or p-1 (p is odd, so p-1 just clears bit zero)
	assign pass = (acc_q == W'(1)) || (acc_q == {cand_q[W-1:1], 1'b0});

	assign out_free    = !res_valid_q || !result_stall;
	assign start_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start_valid) begin
						if (start_big) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_RES;
						end
					end
				end
				S_RES: begin
					if (cnt_q == '0) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (cand_q == W'(1)) begin
						state_q <= S_DONE;
					end else if (rm3_q == '0 || rm5_q == '0 || rm7_q == '0) begin
						state_q <= S_NEXT;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if ((phase_q || !mplier_q[W-1]) && cnt_q == '0) begin
						state_q <= S_EXP;
					end
				end
				S_EXP: begin
					if ((sq_q && exp_word[ebit_q]) || ebit_q != '0) begin
						state_q <= S_MUL;
					end else if (!pass) begin
						state_q <= S_NEXT;
					end else if (!base5_q) begin
						state_q <= S_MUL;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_NEXT: begin
					if (&cand_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_RES;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cand_q   <= start_cand;
				mplier_q <= start_cand;
				cnt_q    <= CW'(W - 1);
				rm3_q    <= '0;
				rm5_q    <= '0;
				rm7_q    <= '0;
				ovf_q    <= start_big;
			end
			S_RES: begin
				rm3_q    <= res_step(rm3_q, mplier_q[W-1], MOD3);
				rm5_q    <= res_step(rm5_q, mplier_q[W-1], MOD5);
				rm7_q    <= res_step(rm7_q, mplier_q[W-1], MOD7);
				mplier_q <= mplier_q << 1;
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
			S_EVAL: begin
				// first square of the base-3 test starts from r = 1
				base5_q  <= 1'b0;
				sq_q     <= 1'b1;
				ebit_q   <= CW'(W - 2);
				acc_q    <= '0;
				mcand_q  <= W'(1);
				mplier_q <= W'(1);
				cnt_q    <= CW'(W - 1);
				phase_q  <= 1'b0;
			end
			S_MUL: begin
				acc_q <= red;
				if (!phase_q && mplier_q[W-1]) begin
					phase_q <= 1'b1;
				end else begin
					phase_q  <= 1'b0;
					mplier_q <= mplier_q << 1;
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
			end
			S_EXP: begin
				acc_q   <= '0;
				cnt_q   <= CW'(W - 1);
				phase_q <= 1'b0;
				if (sq_q && exp_word[ebit_q]) begin
					sq_q     <= 1'b0;
					mcand_q  <= acc_q;
					mplier_q <= base_val;
				end else if (ebit_q != '0) begin
					sq_q     <= 1'b1;
					ebit_q   <= ebit_q - CW'(1);
					mcand_q  <= acc_q;
					mplier_q <= acc_q;
				end else begin
					// base 3 passed: restart the ladder for base 5
					base5_q  <= 1'b1;
					sq_q     <= 1'b1;
					ebit_q   <= CW'(W - 2);
					mcand_q  <= W'(1);
					mplier_q <= W'(1);
				end
			end
			S_NEXT: begin
				cand_q   <= cand_plus2;
				mplier_q <= cand_plus2;
				cnt_q    <= CW'(W - 1);
				rm3_q    <= '0;
				rm5_q    <= '0;
				rm7_q    <= '0;
				ovf_q    <= &cand_q;
			end
			default: begin
			end
		endcase
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			prime_q   <= ovf_q ? '0 : cand_ext[FIELD_W-1:0];
			res_ovf_q <= ovf_q;
		end
	end

	assign result_valid = res_valid_q;
	assign prime_found  = prime_q;
	assign overflow     = res_ovf_q;

endmodule
`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
// self-checking bench for next_probable_prime_search_top: directed and random starts
module tb_top;
	import npps_pkg::*;

	localparam int unsigned VALUE_W = 32;
	localparam longint unsigned LIMIT_CYCLES = 64'd10_000_000;
	localparam int SETTLE_CYCLES = 64;

	typedef struct packed {
		field_t prime;
		logic   ovf;
	} search_result_t;

	typedef enum int {
		STALL_NONE,
		STALL_HALF,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   start_valid = 1'b0;
	logic   start_stall;
	field_t start_value = '0;
	logic   result_valid;
	logic   result_stall = 1'b0;
	field_t prime_found;
	logic   overflow;

	search_result_t  pending_results[$];
	int              mismatch_count = 0;
	int              burst_left = 0;
	longint unsigned cycle_count = 0;
	stall_mode_t     stall_mode = STALL_NONE;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	next_probable_prime_search_top #(
		.VALUE_WIDTH(VALUE_W)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start_valid (start_valid),
		.start_stall (start_stall),
		.start_value (start_value),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.prime_found (prime_found),
		.overflow    (overflow)
	);

	// moduli stay below 2^32, so the plain product fits in 64 bits
	function automatic logic [63:0] mul_mod64(input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] m);
		return (a * b) % m;
	endfunction

	// a zero exponent gives 1 with no reduction, which lets the candidate one through
	function automatic logic [63:0] pow_mod64(input logic [63:0] base, input logic [63:0] ex,
			input logic [63:0] m);
		logic [63:0] acc;
		logic [63:0] sq;
		acc = 64'd1;
		sq = base % m;
		if (ex != 64'd0) begin
			acc = acc % m;
		end
		while (ex != 64'd0) begin
			if (ex[0]) begin
				acc = mul_mod64(acc, sq, m);
			end
			sq = mul_mod64(sq, sq, m);
			ex = ex >> 1;
		end
		return acc;
	endfunction

	function automatic bit euler_base_ok(input logic [63:0] base, input logic [63:0] cand);
		logic [63:0] e;
		e = pow_mod64(base, (cand - 64'd1) >> 1, cand);
		return (e == 64'd1) || (e == cand - 64'd1);
	endfunction

	// base 7 only has to be coprime, its power is never looked at
	function automatic bit probable_prime(input logic [63:0] cand);
		if (!cand[0]) begin
			return 1'b0;
		end
		if (cand % 3 == 0 || !euler_base_ok(64'd3, cand)) begin
			return 1'b0;
		end
		if (cand % 5 == 0 || !euler_base_ok(64'd5, cand)) begin
			return 1'b0;
		end
		return (cand % 7 != 0);
	endfunction

	function automatic search_result_t predict_search(input field_t start);
		logic [63:0]    cand;
		logic [63:0]    top;
		search_result_t res;
		bit             done;
		top = (64'd1 << VALUE_W) - 64'd1;
		res = '0;
		cand = {32'd0, start};
		if (cand > top) begin
			res.ovf = 1'b1;
		end else begin
			if (!cand[0]) begin
				cand = cand + 64'd1;
			end
			done = 1'b0;
			while (!done) begin
				if (probable_prime(cand)) begin
					res.prime = field_t'(cand);
					done = 1'b1;
				end else if (top - cand < 64'd2) begin
					res.ovf = 1'b1;
					done = 1'b1;
				end else begin
					cand = cand + 64'd2;
				end
			end
		end
		return res;
	endfunction

	// sends one start word; the sender works in bursts with idle gaps between them
	task automatic send_word(input field_t value);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			start_valid <= 1'b0;
			start_value <= field_t'($urandom);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 6);
		end
		start_valid <= 1'b1;
		start_value <= value;
		do @(posedge clk); while (start_stall);
		pending_results.push_back(predict_search(value));
		burst_left--;
	endtask

	// small starts: candidate one, the rejected bases, carmichael-like composites
	task automatic test_low_starts();
		field_t low_list[15] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 11, 13, 25, 561, 1105};
		foreach (low_list[i]) begin
			send_word(low_list[i]);
		end
	endtask

	task automatic test_bit_patterns();
		field_t pat_list[4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555};
		foreach (pat_list[i]) begin
			send_word(pat_list[i]);
		end
	endtask

	// around the largest 32-bit prime, where the search runs off the top
	task automatic test_top_overflow();
		field_t top_list[5] = '{32'hFFFF_FFFB, 32'hFFFF_FFFC, 32'hFFFF_FFFD, 32'hFFFF_FFFE,
			32'hFFFF_FFFF};
		foreach (top_list[i]) begin
			send_word(top_list[i]);
		end
	endtask

	task automatic test_random_full();
		repeat (40) send_word(field_t'($urandom));
	endtask

	task automatic test_random_low();
		repeat (20) send_word(field_t'($urandom_range(0, 2000)));
	endtask

	task automatic test_random_top();
		repeat (20) send_word(field_t'(32'hFFFF_FFFF - $urandom_range(0, 1023)));
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("next_probable_prime_search_top test failed");
			$finish;
		end
	end

	// receiver stall pattern, its mode picked at random from none, half, heavy and periodic
	always @(posedge clk) begin
		if (cycle_count % 256 == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
		end
		case (stall_mode)
			STALL_NONE: begin
				result_stall <= 1'b0;
			end
			STALL_HALF: begin
				result_stall <= 1'($urandom_range(0, 1));
			end
			STALL_HEAVY: begin
				result_stall <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				result_stall <= (cycle_count % 5 < 2);
			end
		endcase
	end

	always @(posedge clk) begin
		search_result_t exp_res;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$error("result word with none expected: prime_found %0d overflow %0b",
					prime_found, overflow);
				mismatch_count++;
			end else begin
				exp_res = pending_results.pop_front();
				if (prime_found !== exp_res.prime) begin
					$error("prime_found: expected %0d, got %0d", exp_res.prime, prime_found);
					mismatch_count++;
				end
				if (overflow !== exp_res.ovf) begin
					$error("overflow: expected %0b, got %0b", exp_res.ovf, overflow);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_low_starts();
		test_bit_patterns();
		test_top_overflow();
		test_random_full();
		test_random_low();
		test_random_top();
		start_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("next_probable_prime_search_top test passed");
		end else begin
			$display("next_probable_prime_search_top test failed");
		end
		$finish;
	end

endmodule
